/* rtl/ir_pulse_frame_decoder_unit_assert.svh */
// Assertion macros for the pulse frame decoder modules, used by ipfd_frame.
`ifndef IR_PULSE_FRAME_DECODER_UNIT_ASSERT_SVH
`define IR_PULSE_FRAME_DECODER_UNIT_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define IPFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define IPFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ipfd_pkg.sv */
// Types and constants shared by the pulse frame decoder modules.
package ipfd_pkg;

    localparam int CFG_DUR_W = 15;
    localparam int STATUS_W  = 3;
    localparam int REG_IDX_W = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_SHORT  = 3'd1,
        ST_HEADER = 3'd2,
        ST_BIT    = 3'd3,
        ST_END    = 3'd4
    } t_status;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ACTIVE_LEVEL = 3'd0,
        REG_MARGIN       = 3'd1,
        REG_HEADER_MARK  = 3'd2,
        REG_HEADER_SPACE = 3'd3,
        REG_BIT_MARK     = 3'd4,
        REG_ONE_SPACE    = 3'd5,
        REG_ZERO_SPACE   = 3'd6,
        REG_END_MARK     = 3'd7
    } t_reg_idx;

    localparam logic                 RST_ACTIVE_LEVEL = 1'b1;
    localparam logic [CFG_DUR_W-1:0] RST_MARGIN       = 15'd60;
    localparam logic [CFG_DUR_W-1:0] RST_HEADER_MARK  = 15'd8500;
    localparam logic [CFG_DUR_W-1:0] RST_HEADER_SPACE = 15'd4250;
    localparam logic [CFG_DUR_W-1:0] RST_BIT_MARK     = 15'd560;
    localparam logic [CFG_DUR_W-1:0] RST_ONE_SPACE    = 15'd1600;
    localparam logic [CFG_DUR_W-1:0] RST_ZERO_SPACE   = 15'd560;
    localparam logic [CFG_DUR_W-1:0] RST_END_MARK     = 15'd800;

    typedef struct packed {
        logic                 active_level;
        logic [CFG_DUR_W-1:0] margin;
        logic [CFG_DUR_W-1:0] header_mark;
        logic [CFG_DUR_W-1:0] header_space;
        logic [CFG_DUR_W-1:0] bit_mark;
        logic [CFG_DUR_W-1:0] one_space;
        logic [CFG_DUR_W-1:0] zero_space;
        logic [CFG_DUR_W-1:0] end_mark;
    } t_cfg;

    // Which pulse pair shapes the current word fits.
    typedef struct packed {
        logic header_ok;
        logic one_ok;
        logic zero_ok;
        logic end_ok;
    } t_match;

endpackage

/* rtl/ir_pulse_frame_decoder_unit.sv */
// Top level of the infrared pulse frame decoder.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------------------------
//  in       | in        | i_in_valid / o_in_stall | levels, durations, frame end of a pair
//  out      | out       | o_out_valid / i_out_stall | status, code of a finished frame
//  config   | in        | APB psel/penable/pwrite | eight registers at 4-byte spacing
//
// One pulse pair word per cycle while o_in_stall is low; a pair is registered, then
// classified, folded into the frame state and, at a frame end, into the result register.
// Synchronous reset clears the frame state and both valid flags and loads the config registers with their reset values.
// A stall on the output holds the result register and then the input register.

module ir_pulse_frame_decoder_unit #(
    parameter int DATA_BITS      = 28,
    parameter int DURATION_WIDTH = 15
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_first_level,
    input  logic [DURATION_WIDTH-1:0]           i_first_duration,
    input  logic                                i_second_level,
    input  logic [DURATION_WIDTH-1:0]           i_second_duration,
    input  logic                                i_frame_end,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ipfd_pkg::STATUS_W-1:0]       o_status,
    output logic [DATA_BITS-1:0]                o_code,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ipfd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ipfd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ipfd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    ipfd_pkg::t_cfg            cfg;
    ipfd_pkg::t_match          match;
    logic                      r_p_valid;
    logic                      r_first_level;
    logic [DURATION_WIDTH-1:0] r_first_duration;
    logic                      r_second_level;
    logic [DURATION_WIDTH-1:0] r_second_duration;
    logic                      r_frame_end;
    logic                      out_blocked;
    logic                      advance;

    ipfd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Hold the pair word while the result register cannot take a new value.
    assign out_blocked = o_out_valid && i_out_stall;
    assign advance     = r_p_valid && !out_blocked;
    assign o_in_stall  = r_p_valid && out_blocked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_p_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_first_level     <= i_first_level;
            r_first_duration  <= i_first_duration;
            r_second_level    <= i_second_level;
            r_second_duration <= i_second_duration;
            r_frame_end       <= i_frame_end;
        end
    end

    ipfd_classify #(
        .DURATION_WIDTH (DURATION_WIDTH)
    ) u_classify (
        .i_cfg             (cfg),
        .i_first_level     (r_first_level),
        .i_first_duration  (r_first_duration),
        .i_second_level    (r_second_level),
        .i_second_duration (r_second_duration),
        .o_match           (match)
    );

    ipfd_frame #(
        .DATA_BITS (DATA_BITS)
    ) u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_frame_end (r_frame_end),
        .i_match     (match),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_status    (o_status),
        .o_code      (o_code)
    );

endmodule

/* rtl/ipfd_regs.sv */
// APB configuration registers of the pulse frame decoder.
module ipfd_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ipfd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ipfd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ipfd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output ipfd_pkg::t_cfg                      o_cfg
);

    ipfd_pkg::t_cfg                      r_cfg;
    ipfd_pkg::t_cfg                      n_cfg;
    ipfd_pkg::t_reg_idx                  reg_idx;
    logic [ipfd_pkg::CFG_DUR_W-1:0]      wr_dur;
    logic                                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = ipfd_pkg::t_reg_idx'(paddr[ipfd_pkg::APB_ADDR_W-1:2]);
    assign wr_dur  = pwdata[ipfd_pkg::CFG_DUR_W-1:0];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                ipfd_pkg::REG_ACTIVE_LEVEL: n_cfg.active_level = pwdata[0];
                ipfd_pkg::REG_MARGIN:       n_cfg.margin       = wr_dur;
                ipfd_pkg::REG_HEADER_MARK:  n_cfg.header_mark  = wr_dur;
                ipfd_pkg::REG_HEADER_SPACE: n_cfg.header_space = wr_dur;
                ipfd_pkg::REG_BIT_MARK:     n_cfg.bit_mark     = wr_dur;
                ipfd_pkg::REG_ONE_SPACE:    n_cfg.one_space    = wr_dur;
                ipfd_pkg::REG_ZERO_SPACE:   n_cfg.zero_space   = wr_dur;
                ipfd_pkg::REG_END_MARK:     n_cfg.end_mark     = wr_dur;
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            ipfd_pkg::REG_ACTIVE_LEVEL:
                prdata = ipfd_pkg::APB_DATA_W'(r_cfg.active_level);
            ipfd_pkg::REG_MARGIN:       prdata = ipfd_pkg::APB_DATA_W'(r_cfg.margin);
            ipfd_pkg::REG_HEADER_MARK:  prdata = ipfd_pkg::APB_DATA_W'(r_cfg.header_mark);
            ipfd_pkg::REG_HEADER_SPACE: prdata = ipfd_pkg::APB_DATA_W'(r_cfg.header_space);
            ipfd_pkg::REG_BIT_MARK:     prdata = ipfd_pkg::APB_DATA_W'(r_cfg.bit_mark);
            ipfd_pkg::REG_ONE_SPACE:    prdata = ipfd_pkg::APB_DATA_W'(r_cfg.one_space);
            ipfd_pkg::REG_ZERO_SPACE:   prdata = ipfd_pkg::APB_DATA_W'(r_cfg.zero_space);
            ipfd_pkg::REG_END_MARK:     prdata = ipfd_pkg::APB_DATA_W'(r_cfg.end_mark);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level <= ipfd_pkg::RST_ACTIVE_LEVEL;
            r_cfg.margin       <= ipfd_pkg::RST_MARGIN;
            r_cfg.header_mark  <= ipfd_pkg::RST_HEADER_MARK;
            r_cfg.header_space <= ipfd_pkg::RST_HEADER_SPACE;
            r_cfg.bit_mark     <= ipfd_pkg::RST_BIT_MARK;
            r_cfg.one_space    <= ipfd_pkg::RST_ONE_SPACE;
            r_cfg.zero_space   <= ipfd_pkg::RST_ZERO_SPACE;
            r_cfg.end_mark     <= ipfd_pkg::RST_END_MARK;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/ipfd_classify.sv */
// Window compares of one pulse pair against every target shape.
module ipfd_classify #(
    parameter int DURATION_WIDTH = 15
) (
    input  ipfd_pkg::t_cfg              i_cfg,
    input  logic                        i_first_level,
    input  logic [DURATION_WIDTH-1:0]   i_first_duration,
    input  logic                        i_second_level,
    input  logic [DURATION_WIDTH-1:0]   i_second_duration,
    output ipfd_pkg::t_match            o_match
);

    logic [DURATION_WIDTH-1:0] margin;
    logic [DURATION_WIDTH-1:0] t_hdr_mark;
    logic [DURATION_WIDTH-1:0] t_hdr_space;
    logic [DURATION_WIDTH-1:0] t_bit_mark;
    logic [DURATION_WIDTH-1:0] t_one_space;
    logic [DURATION_WIDTH-1:0] t_zero_space;
    logic [DURATION_WIDTH-1:0] t_end_mark;
    logic                      levels_ok;
    logic                      bit_mark_ok;

    // True when t - m < d < t + m, done unsigned with one guard bit.
    function automatic logic near(input logic [DURATION_WIDTH-1:0] d,
                                  input logic [DURATION_WIDTH-1:0] t,
                                  input logic [DURATION_WIDTH-1:0] m);
        logic [DURATION_WIDTH:0] d_plus_m;
        logic [DURATION_WIDTH:0] t_plus_m;
        d_plus_m = {1'b0, d} + {1'b0, m};
        t_plus_m = {1'b0, t} + {1'b0, m};
        return (d_plus_m > {1'b0, t}) && ({1'b0, d} < t_plus_m);
    endfunction

    // Fit the register targets to the duration width.
    assign margin       = DURATION_WIDTH'(i_cfg.margin);
    assign t_hdr_mark   = DURATION_WIDTH'(i_cfg.header_mark);
    assign t_hdr_space  = DURATION_WIDTH'(i_cfg.header_space);
    assign t_bit_mark   = DURATION_WIDTH'(i_cfg.bit_mark);
    assign t_one_space  = DURATION_WIDTH'(i_cfg.one_space);
    assign t_zero_space = DURATION_WIDTH'(i_cfg.zero_space);
    assign t_end_mark   = DURATION_WIDTH'(i_cfg.end_mark);

    assign levels_ok   = (i_first_level == i_cfg.active_level)
                      && (i_second_level != i_cfg.active_level);
    assign bit_mark_ok = near(i_first_duration, t_bit_mark, margin);

    assign o_match.header_ok = levels_ok
        && near(i_first_duration, t_hdr_mark, margin)
        && near(i_second_duration, t_hdr_space, margin);
    assign o_match.one_ok  = levels_ok && bit_mark_ok
        && near(i_second_duration, t_one_space, margin);
    assign o_match.zero_ok = levels_ok && bit_mark_ok
        && near(i_second_duration, t_zero_space, margin);
    assign o_match.end_ok  = levels_ok
        && near(i_first_duration, t_end_mark, margin)
        && near(i_second_duration, '0, margin);

endmodule

/* rtl/ipfd_frame.sv */
// Frame position tracking, bit shifter, error capture and result register.
`include "ir_pulse_frame_decoder_unit_assert.svh"

module ipfd_frame #(
    parameter int DATA_BITS = 28
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_advance,
    input  logic                            i_frame_end,
    input  ipfd_pkg::t_match                i_match,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic [ipfd_pkg::STATUS_W-1:0]   o_status,
    output logic [DATA_BITS-1:0]            o_code
);

    localparam int IDX_W = $clog2(DATA_BITS + 3);
    localparam logic [IDX_W-1:0] LAST_BIT    = IDX_W'(DATA_BITS);
    localparam logic [IDX_W-1:0] END_PAIR    = IDX_W'(DATA_BITS + 1);
    localparam logic [IDX_W-1:0] FRAME_PAIRS = IDX_W'(DATA_BITS + 2);

    logic [IDX_W-1:0]       r_pair_index;
    logic [IDX_W-1:0]       n_pair_index;
    logic [DATA_BITS-1:0]   r_shift;
    logic [DATA_BITS-1:0]   n_shift;
    ipfd_pkg::t_status      r_first_error;
    ipfd_pkg::t_status      n_first_error;
    ipfd_pkg::t_status      pair_err;
    ipfd_pkg::t_status      frame_status;
    logic                   r_out_valid;
    ipfd_pkg::t_status      r_status;
    logic [DATA_BITS-1:0]   r_code;

    always_comb begin
        pair_err = ipfd_pkg::ST_OK;
        n_shift  = r_shift;
        if (r_pair_index == '0) begin
            if (!i_match.header_ok) begin
                pair_err = ipfd_pkg::ST_HEADER;
            end
        end else if (r_pair_index <= LAST_BIT) begin
            // A pair fitting both bit shapes decodes as one.
            n_shift = (r_shift << 1) | DATA_BITS'(i_match.one_ok);
            if (!i_match.one_ok && !i_match.zero_ok) begin
                pair_err = ipfd_pkg::ST_BIT;
            end
        end else if (r_pair_index == END_PAIR) begin
            if (!i_match.end_ok) begin
                pair_err = ipfd_pkg::ST_END;
            end
        end

        n_first_error = (r_first_error == ipfd_pkg::ST_OK) ? pair_err : r_first_error;
        // Saturate once the end mark has passed.
        n_pair_index  = (r_pair_index < FRAME_PAIRS) ? r_pair_index + 1'b1 : r_pair_index;

        // Too short wins over any earlier error.
        frame_status = (n_pair_index < FRAME_PAIRS) ? ipfd_pkg::ST_SHORT : n_first_error;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_index  <= '0;
            r_shift       <= '0;
            r_first_error <= ipfd_pkg::ST_OK;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_advance) begin
                if (i_frame_end) begin
                    r_pair_index  <= '0;
                    r_shift       <= '0;
                    r_first_error <= ipfd_pkg::ST_OK;
                end else begin
                    r_pair_index  <= n_pair_index;
                    r_shift       <= n_shift;
                    r_first_error <= n_first_error;
                end
                r_out_valid <= i_frame_end;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && i_frame_end) begin
            r_status <= frame_status;
            r_code   <= (frame_status == ipfd_pkg::ST_OK) ? n_shift : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_code      = r_code;

    `IPFD_ASSERT_NEXT(a_frame_clears, i_advance && i_frame_end, r_pair_index == '0 && r_first_error == ipfd_pkg::ST_OK, "frame state not cleared after frame end")
    `IPFD_ASSERT_NOW(a_index_bound, 1'b1, r_pair_index <= FRAME_PAIRS, "pair index beyond frame length")
    `IPFD_ASSERT_NOW(a_code_only_ok, r_out_valid && r_status != ipfd_pkg::ST_OK, r_code == '0, "code nonzero on a failed frame")
    `IPFD_ASSERT_NOW(a_no_overwrite, r_out_valid && i_out_stall, !i_advance, "pending result overwritten")

endmodule
